// ----- rtl/heightmap_normal_map_encoder_assert.svh -----
// Assertion macros used by the encoder's queue module.
`ifndef HEIGHTMAP_NORMAL_MAP_ENCODER_ASSERT_SVH
`define HEIGHTMAP_NORMAL_MAP_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold on every rising clock edge out of reset
`define HNM_ASSERT(label, clk, rst_n, prop) \
label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hnm assertion failed");
// consequent must hold in the cycle after the antecedent
`define HNM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hnm assertion failed");
`else
`define HNM_ASSERT(label, clk, rst_n, prop)
`define HNM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/hnm_pkg.sv -----
// Types and constants shared by the height map normal encoder.
package hnm_pkg;

    localparam int IDX_W      = 11;
    localparam int HOUT_W     = 16;
    localparam int CFG_RESET  = 1024;

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic             sel;
        logic             last_row;
        logic             last_col;
    } hnm_item_t;

    typedef struct packed {
        logic signed [7:0] x;
        logic        [6:0] y;
        logic signed [7:0] z;
    } hnm_normal_t;

    typedef struct packed {
        logic [HOUT_W-1:0] height;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        hnm_normal_t       normal;
        logic              eof;
    } hnm_result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD_L,
        B_RD_S,
        B_RD_R,
        B_WR,
        B_JOB,
        B_WAIT
    } back_state_t;

    typedef enum logic [1:0] {
        N_IDLE,
        N_SQ,
        N_ITER,
        N_DONE
    } norm_state_t;

    typedef enum logic [1:0] {
        JOB_ABOVE,
        JOB_LEFT,
        JOB_CORNER
    } job_t;

endpackage

// ----- rtl/hnm_fifo.sv -----
// Small register queue used between front, back and result port.
module hnm_fifo
    import hnm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

`include "heightmap_normal_map_encoder_assert.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    `HNM_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `HNM_ASSERT_NEXT(a_count_up, clk, rst_n, push_ok && !pop_ok, count_reg == $past(count_reg) + 1'b1)
    `HNM_ASSERT_NEXT(a_count_down, clk, rst_n, pop_ok && !push_ok, count_reg == $past(count_reg) - 1'b1)

endmodule

// ----- rtl/hnm_front.sv -----
// Front end: limit register, raster counters and item classification.
module hnm_front
    import hnm_pkg::*;
#(
    parameter int MAX_LAST_INDEX = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_value,
    input  logic             take,
    output hnm_item_t        item
);

    logic [IDX_W-1:0] limit_reg;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic             sel_reg, sel_next;
    logic [IDX_W-1:0] last;

    // zero acts as one, anything above the last store index is clamped to it
    always_comb
    begin
        if (limit_reg == '0)
        begin
            last = IDX_W'(1);
        end
        else if (32'(limit_reg) > MAX_LAST_INDEX)
        begin
            last = IDX_W'(MAX_LAST_INDEX);
        end
        else
        begin
            last = limit_reg;
        end
    end

    always_comb
    begin
        item.col      = col_reg;
        item.row      = row_reg;
        item.sel      = sel_reg;
        item.last_row = (row_reg == last);
        item.last_col = (col_reg == last);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        sel_next = sel_reg;
        if (cfg_write)
        begin
            col_next = '0;
            row_next = '0;
            sel_next = 1'b0;
        end
        else if (take)
        begin
            if (item.last_col)
            begin
                col_next = '0;
                if (item.last_row)
                begin
                    row_next = '0;
                    sel_next = 1'b0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    sel_next = !sel_reg;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= IDX_W'(CFG_RESET);
            col_reg   <= '0;
            row_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= cfg_value;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            sel_reg <= sel_next;
        end
    end

endmodule

// ----- rtl/hnm_norm.sv -----
// Iterative normal unit: one trial bit per cycle for all three components.
module hnm_norm
    import hnm_pkg::*;
#(
    parameter int HEIGHT_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [HEIGHT_BITS:0] dx,
    input  logic signed [HEIGHT_BITS:0] dz,
    output logic                       done,
    output hnm_normal_t                normal
);

    localparam int MAG_W  = HEIGHT_BITS + 1;
    localparam int SUM_W  = 2 * MAG_W + 1;
    localparam int PROD_W = SUM_W + 14;
    localparam logic [PROD_W-1:0] LIM_Y = PROD_W'(400) << 14;

    norm_state_t      state_reg, state_next;
    logic [MAG_W-1:0] ax_reg, az_reg;
    logic             sx_reg, sz_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [PROD_W-1:0] lim_reg [3];
    logic [6:0]       lo_reg [3];
    logic [13:0]      sq_reg [3];
    logic [2:0]       bit_reg;
    logic [2*MAG_W-1:0] ax2, az2;
    logic [13:0]      trial_sq [3];
    logic [PROD_W-1:0] prod [3];
    logic             fit [3];

    assign ax2 = ax_reg * ax_reg;
    assign az2 = az_reg * az_reg;

    // trial k = lo | bit, k*k built from lo*lo by shifts and adds
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial_sq[i] = sq_reg[i] + (14'(lo_reg[i]) << (bit_reg + 3'd1))
                        + (14'(1) << {bit_reg, 1'b0});
            prod[i]     = trial_sq[i] * sum_reg;
            fit[i]      = (prod[i] <= lim_reg[i]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE, N_DONE:
            begin
                if (start)
                begin
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                state_next = N_ITER;
            end
            N_ITER:
            begin
                if (bit_reg == '0)
                begin
                    state_next = N_DONE;
                end
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == N_IDLE || state_reg == N_DONE) && start)
        begin
            ax_reg <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            az_reg <= dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
            sx_reg <= dx[MAG_W-1];
            sz_reg <= dz[MAG_W-1];
        end
        if (state_reg == N_SQ)
        begin
            sum_reg    <= SUM_W'(ax2) + SUM_W'(az2) + SUM_W'(400);
            lim_reg[0] <= PROD_W'(ax2) << 14;
            lim_reg[1] <= LIM_Y;
            lim_reg[2] <= PROD_W'(az2) << 14;
            bit_reg    <= 3'd6;
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= '0;
                sq_reg[i] <= '0;
            end
        end
        if (state_reg == N_ITER)
        begin
            bit_reg <= bit_reg - 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                if (fit[i])
                begin
                    lo_reg[i] <= lo_reg[i] | (7'(1) << bit_reg);
                    sq_reg[i] <= trial_sq[i];
                end
            end
        end
    end

    assign done     = (state_reg == N_DONE);
    assign normal.x = sx_reg ? 8'(0) - {1'b0, lo_reg[0]} : {1'b0, lo_reg[0]};
    assign normal.y = lo_reg[1];
    assign normal.z = sz_reg ? 8'(0) - {1'b0, lo_reg[2]} : {1'b0, lo_reg[2]};

endmodule

// ----- rtl/hnm_back.sv -----
// Back end: line stores, neighbor fetch and result sequencing.
module hnm_back
    import hnm_pkg::*;
#(
    parameter int MAX_LAST_INDEX = 1024,
    parameter int HEIGHT_BITS    = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  hnm_item_t              q_item,
    input  logic [HEIGHT_BITS-1:0] q_height,
    output logic                   q_pop,
    input  logic                   res_full,
    output logic                   res_push,
    output hnm_result_t            res
);

    localparam int DEPTH  = MAX_LAST_INDEX + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [HEIGHT_BITS-1:0] mem0 [DEPTH];
    logic [HEIGHT_BITS-1:0] mem1 [DEPTH];
    logic [HEIGHT_BITS-1:0] q0_reg, q1_reg;
    logic [ADDR_W-1:0]      a0, a1, prev_addr, cur_addr;
    logic                   we0, we1, wr_en;
    logic [HEIGHT_BITS-1:0] prev_q, cur_q;

    back_state_t            state_reg, state_next;
    job_t                   job_reg, job_next;
    hnm_item_t              item_reg;
    logic [HEIGHT_BITS-1:0] h_reg, h1_reg, h2_reg;
    logic [HEIGHT_BITS-1:0] left_reg, self_reg, right_reg, down_reg;

    logic [HEIGHT_BITS-1:0] j_self, j_left, j_right, j_down, j_up;
    logic                   job_active, finish, norm_start, norm_done;
    logic signed [HEIGHT_BITS:0] dx, dz;
    hnm_normal_t            normal;

    // bank roles swap every row
    assign prev_q = item_reg.sel ? q0_reg : q1_reg;
    assign cur_q  = item_reg.sel ? q1_reg : q0_reg;
    assign cur_addr = ADDR_W'(item_reg.col);
    assign a0  = item_reg.sel ? prev_addr : cur_addr;
    assign a1  = item_reg.sel ? cur_addr : prev_addr;
    assign we0 = wr_en && !item_reg.sel;
    assign we1 = wr_en && item_reg.sel;

    always_comb
    begin
        unique case (state_reg)
            B_RD_L:  prev_addr = (item_reg.col == '0) ? ADDR_W'(item_reg.col)
                                                      : ADDR_W'(item_reg.col - 1'b1);
            B_RD_R:  prev_addr = item_reg.last_col ? ADDR_W'(item_reg.col)
                                                   : ADDR_W'(item_reg.col + 1'b1);
            default: prev_addr = ADDR_W'(item_reg.col);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[a0] <= h_reg;
        end
        q0_reg <= mem0[a0];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[a1] <= h_reg;
        end
        q1_reg <= mem1[a1];
    end

    // operands of the vertex being worked out
    always_comb
    begin
        j_self  = self_reg;
        j_left  = left_reg;
        j_right = right_reg;
        j_down  = down_reg;
        j_up    = h_reg;
        res.col = item_reg.col;
        res.row = item_reg.row - 1'b1;
        res.eof = 1'b0;
        job_active = (item_reg.row != '0);
        unique case (job_reg)
            JOB_ABOVE:
            begin
            end
            JOB_LEFT:
            begin
                j_self  = h1_reg;
                j_left  = (item_reg.col >= IDX_W'(2)) ? h2_reg : h1_reg;
                j_right = h_reg;
                j_down  = left_reg;
                j_up    = h1_reg;
                res.col = item_reg.col - 1'b1;
                res.row = item_reg.row;
                job_active = item_reg.last_row && (item_reg.col != '0);
            end
            JOB_CORNER:
            begin
                j_self  = h_reg;
                j_left  = h1_reg;
                j_right = h_reg;
                j_down  = self_reg;
                j_up    = h_reg;
                res.col = item_reg.col;
                res.row = item_reg.row;
                res.eof = 1'b1;
                job_active = item_reg.last_row && item_reg.last_col;
            end
            default:
            begin
            end
        endcase
        res.height = HOUT_W'(j_self);
        res.normal = normal;
    end

    assign dx         = $signed({j_left[HEIGHT_BITS-1], j_left})
                      - $signed({j_right[HEIGHT_BITS-1], j_right});
    assign dz         = $signed({j_down[HEIGHT_BITS-1], j_down})
                      - $signed({j_up[HEIGHT_BITS-1], j_up});

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        norm_start = 1'b0;
        res_push   = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_RD_L;
                end
            end
            B_RD_L:  state_next = B_RD_S;
            B_RD_S:  state_next = B_RD_R;
            B_RD_R:  state_next = B_WR;
            B_WR:
            begin
                wr_en      = 1'b1;
                job_next   = JOB_ABOVE;
                state_next = B_JOB;
            end
            B_JOB:
            begin
                if (job_active)
                begin
                    norm_start = 1'b1;
                    state_next = B_WAIT;
                end
                else if (job_reg == JOB_CORNER)
                begin
                    finish     = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    job_next = job_t'(job_reg + 1'b1);
                end
            end
            B_WAIT:
            begin
                if (norm_done && !res_full)
                begin
                    res_push = 1'b1;
                    if (job_reg == JOB_CORNER)
                    begin
                        finish     = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        job_next   = job_t'(job_reg + 1'b1);
                        state_next = B_JOB;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            job_reg   <= JOB_ABOVE;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
            h_reg    <= q_height;
        end
        if (state_reg == B_RD_S)
        begin
            left_reg <= prev_q;
            down_reg <= cur_q;
        end
        if (state_reg == B_RD_R)
        begin
            self_reg <= prev_q;
        end
        if (state_reg == B_WR)
        begin
            right_reg <= prev_q;
            // no row two above: the vertex stands in
            if (item_reg.row < IDX_W'(2))
            begin
                down_reg <= self_reg;
            end
        end
        if (finish)
        begin
            h2_reg <= h1_reg;
            h1_reg <= h_reg;
        end
    end

    hnm_norm #(
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .dx     (dx),
        .dz     (dz),
        .done   (norm_done),
        .normal (normal)
    );

endmodule

// ----- rtl/heightmap_normal_map_encoder.sv -----
// Top level of the height map to 8-bit normal map encoder.
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------
//  input     push / full        height_tenths
//  result    empty / pop        height_out, column, row, normal_x/y/z,
//                               end_of_frame
//  config    cfg_valid / ready  cfg_data (grid_last_index)
//
// Sequence: the back end pops an item, makes three line store reads and one
// write, then checks three jobs; each result waits for the normal unit,
// which settles one bit of k per cycle over 7 steps, and for room in the
// result queue.
// The front end and a 4-item queue take items while the back end works.
// Reset: counters clear, limit returns to 1024; line stores are not cleared.
// Stalls: a full result queue holds the back end; cfg is always ready.
module heightmap_normal_map_encoder
    import hnm_pkg::*;
#(
    parameter int MAX_LAST_INDEX = 1024,
    parameter int HEIGHT_BITS    = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [HEIGHT_BITS-1:0] height_tenths,
    output logic                   empty,
    input  logic                   pop,
    output logic [HOUT_W-1:0]      height_out,
    output logic [IDX_W-1:0]       column,
    output logic [IDX_W-1:0]       row,
    output logic signed [7:0]      normal_x,
    output logic [6:0]             normal_y,
    output logic signed [7:0]      normal_z,
    output logic                   end_of_frame,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IDX_W-1:0]       cfg_data
);

    localparam int ITEM_W = HEIGHT_BITS + $bits(hnm_item_t);
    localparam int RES_W  = $bits(hnm_result_t);

    hnm_item_t              front_item, q_item;
    logic                   take;
    logic                   q_empty, q_pop;
    logic [HEIGHT_BITS-1:0] q_height;
    logic [ITEM_W-1:0]      q_dout;
    logic                   res_full, res_push;
    hnm_result_t            res_in, res_out;
    logic [RES_W-1:0]       res_dout;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    hnm_front #(
        .MAX_LAST_INDEX(MAX_LAST_INDEX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .take      (take),
        .item      (front_item)
    );

    // classified items waiting for the back end
    hnm_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(4)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({height_tenths, front_item}),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign {q_height, q_item} = q_dout;

    hnm_back #(
        .MAX_LAST_INDEX(MAX_LAST_INDEX),
        .HEIGHT_BITS   (HEIGHT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_height (q_height),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    // finished results, oldest on the ports
    hnm_fifo #(
        .WIDTH(RES_W),
        .DEPTH(4)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign res_out      = hnm_result_t'(res_dout);
    assign height_out   = res_out.height;
    assign column       = res_out.col;
    assign row          = res_out.row;
    assign normal_x     = res_out.normal.x;
    assign normal_y     = res_out.normal.y;
    assign normal_z     = res_out.normal.z;
    assign end_of_frame = res_out.eof;

endmodule
